@@ design/afsk_pkg.sv @@
// ----------------------------------------------------------------------------
// AFSK demodulator package
// Shared types, constants and coefficient tables for the Bell 202 demodulator.
// ----------------------------------------------------------------------------
package afsk_pkg;

  // Default bit timing: samples per bit and phase increment per sample.
  localparam int SAMPLES_PER_BIT_DEF = 8;
  localparam int PHASE_STEP_DEF      = 8;

  // Filter lengths.
  localparam int PRE_TAPS   = 5;
  localparam int MARK_TAPS  = 11;
  localparam int SPACE_TAPS = 11;
  localparam int LP_TAPS    = 8;
  localparam int TAP_W      = $clog2(MARK_TAPS);

  // Prefilter selection codes.
  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_PREEMP = 2'd1;
  localparam logic [1:0] MODE_DEEMP  = 2'd2;

  // Sign patterns over the last four samples that decide a one.
  localparam logic [3:0] PAT_A = 4'h0f;
  localparam logic [3:0] PAT_B = 4'h07;
  localparam logic [3:0] PAT_C = 4'h0b;
  localparam logic [3:0] PAT_D = 4'h0d;
  localparam logic [3:0] PAT_E = 4'h0e;
  localparam logic [3:0] PAT_F = 4'h03;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE,
    ST_DEEM,
    ST_MARK,
    ST_SPACE,
    ST_LP,
    ST_DECIDE,
    ST_EMIT
  } afsk_state_t;

  // Control of the shared multiply-accumulate unit.
  typedef struct packed {
    logic en;   // take a product this cycle
    logic clr;  // first tap: load the product instead of adding it
  } mac_ctrl_t;

  // Pre-emphasis coefficients.
  function automatic logic signed [7:0] preemph_coef(input logic [TAP_W-1:0] idx);
    case (idx)
      4'd0:    preemph_coef = -8'sd18;
      4'd1:    preemph_coef = -8'sd29;
      4'd2:    preemph_coef = 8'sd93;
      4'd3:    preemph_coef = -8'sd29;
      4'd4:    preemph_coef = -8'sd18;
      default: preemph_coef = 8'sd0;
    endcase
  endfunction

  // De-emphasis coefficients.
  function automatic logic signed [7:0] deemph_coef(input logic [TAP_W-1:0] idx);
    case (idx)
      4'd0:    deemph_coef = 8'sd6;
      4'd1:    deemph_coef = 8'sd39;
      4'd2:    deemph_coef = 8'sd60;
      4'd3:    deemph_coef = 8'sd39;
      4'd4:    deemph_coef = 8'sd6;
      default: deemph_coef = 8'sd0;
    endcase
  endfunction

  // 1200 Hz bandpass coefficients.
  function automatic logic signed [7:0] mark_coef(input logic [TAP_W-1:0] idx);
    case (idx)
      4'd0:    mark_coef = -8'sd12;
      4'd1:    mark_coef = -8'sd16;
      4'd2:    mark_coef = -8'sd15;
      4'd3:    mark_coef = 8'sd0;
      4'd4:    mark_coef = 8'sd20;
      4'd5:    mark_coef = 8'sd29;
      4'd6:    mark_coef = 8'sd20;
      4'd7:    mark_coef = 8'sd0;
      4'd8:    mark_coef = -8'sd15;
      4'd9:    mark_coef = -8'sd16;
      4'd10:   mark_coef = -8'sd12;
      default: mark_coef = 8'sd0;
    endcase
  endfunction

  // 2200 Hz bandpass coefficients.
  function automatic logic signed [7:0] space_coef(input logic [TAP_W-1:0] idx);
    case (idx)
      4'd0:    space_coef = 8'sd11;
      4'd1:    space_coef = 8'sd15;
      4'd2:    space_coef = -8'sd8;
      4'd3:    space_coef = -8'sd26;
      4'd4:    space_coef = 8'sd4;
      4'd5:    space_coef = 8'sd30;
      4'd6:    space_coef = 8'sd4;
      4'd7:    space_coef = -8'sd26;
      4'd8:    space_coef = -8'sd8;
      4'd9:    space_coef = 8'sd15;
      4'd10:   space_coef = 8'sd11;
      default: space_coef = 8'sd0;
    endcase
  endfunction

  // Lowpass coefficients.
  function automatic logic signed [7:0] lowpass_coef(input logic [TAP_W-1:0] idx);
    case (idx)
      4'd0:    lowpass_coef = -8'sd9;
      4'd1:    lowpass_coef = 8'sd3;
      4'd2:    lowpass_coef = 8'sd26;
      4'd3:    lowpass_coef = 8'sd47;
      4'd4:    lowpass_coef = 8'sd47;
      4'd5:    lowpass_coef = 8'sd26;
      4'd6:    lowpass_coef = 8'sd3;
      4'd7:    lowpass_coef = -8'sd9;
      default: lowpass_coef = 8'sd0;
    endcase
  endfunction

  // Divide a 16-bit sum by 128 toward zero and keep the low 8 bits.
  function automatic logic signed [7:0] fir_scale(input logic signed [15:0] sum);
    logic signed [15:0] biased;
    biased = sum + (sum[15] ? 16'sd127 : 16'sd0);
    fir_scale = biased[14:7];
  endfunction

  // Two's complement magnitude, wrapped to 8 bits.
  function automatic logic [7:0] mag8(input logic signed [7:0] v);
    mag8 = v[7] ? (~v + 8'd1) : v;
  endfunction

  // True when the recent sign pattern decides a one.
  function automatic logic is_one_pattern(input logic [3:0] pat);
    is_one_pattern = pat inside {PAT_A, PAT_B, PAT_C, PAT_D, PAT_E, PAT_F};
  endfunction

endpackage

@@ design/afsk_mac.sv @@
// ----------------------------------------------------------------------------
// AFSK shared multiply-accumulate unit
// One 8x8 signed multiplier with a 16-bit wrapping accumulator, shared by all
// filters; also presents the scaled filter output for the last tap.
// ----------------------------------------------------------------------------
module afsk_mac (
  input  logic                     clk,
  input  afsk_pkg::mac_ctrl_t      ctrl,
  input  logic signed [7:0]        sample,
  input  logic signed [7:0]        coef,
  output logic signed [7:0]        fir_q
);
  import afsk_pkg::*;

  logic signed [15:0] acc;
  logic signed [15:0] acc_next;
  logic signed [15:0] product;

  // Product and running sum; the sum wraps at 16 bits.
  always_comb begin
    product  = sample * coef;
    acc_next = ctrl.clr ? product : acc + product;
    fir_q    = fir_scale(acc_next);
  end

  // Accumulator register.
  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      acc <= acc_next;
    end
  end

endmodule

@@ design/afsk_bell202_demodulator.sv @@
// ----------------------------------------------------------------------------
// Bell 202 AFSK demodulator
// Filters 8-bit audio samples, recovers 1200 baud bit timing and packs the
// NRZI-decoded bits into bytes, first received bit in bit 0.
// ----------------------------------------------------------------------------
// Usage:
//   Audio samples enter on the s_* stream, one signed sample per word.
//   Decoded bytes leave on the m_* stream; a sample gives zero or one byte.
//   The prefilter is chosen through prefilter_mode_we / prefilter_mode_wdata
//   (0 none, 1 pre-emphasis, 2 de-emphasis, 3 as none); write it while idle.
//   All filter taps run through one shared multiplier, one tap per cycle, so
//   a sample passes through the prefilter (if on), the mark, space and lowpass
//   filters and a decision step, then an emit step when a byte is produced.
//   s_tready is high only between samples.
//   The byte sits in an output register; a new sample is accepted while it
//   waits. If a second byte is ready before the first is taken, the block
//   holds with s_tready low until m_tready frees the register.
//   Synchronous reset clears all delay lines, bit timing and byte assembly,
//   and sets the prefilter to none.
// ----------------------------------------------------------------------------
module afsk_bell202_demodulator #(
  parameter int SAMPLES_PER_BIT = afsk_pkg::SAMPLES_PER_BIT_DEF,
  parameter int PHASE_STEP      = afsk_pkg::PHASE_STEP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,              // [7:0] audio_sample
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,              // [7:0] data_byte
  input  logic       prefilter_mode_we,
  input  logic [1:0] prefilter_mode_wdata
);
  import afsk_pkg::*;

  localparam int PHASE_LIMIT = SAMPLES_PER_BIT * PHASE_STEP;
  localparam int PHASE_MID   = PHASE_LIMIT / 2;
  localparam int PW          = $clog2(PHASE_LIMIT + PHASE_STEP + 1);

  afsk_state_t        state, state_next;
  logic [TAP_W-1:0]   tap, tap_next;
  logic               tap_last;
  logic [1:0]         mode;

  logic signed [7:0]  pre_dly   [PRE_TAPS];
  logic signed [7:0]  deem_dly  [PRE_TAPS];
  logic signed [7:0]  mark_dly  [MARK_TAPS];
  logic signed [7:0]  space_dly [SPACE_TAPS];
  logic signed [7:0]  lp_dly    [LP_TAPS];

  logic signed [7:0]  mark_val;
  logic [3:0]         sign_hist;
  logic [PW-1:0]      bit_phase;
  logic [1:0]         decided;
  logic [7:0]         byte_shift;
  logic [2:0]         bits_in_byte;

  mac_ctrl_t          mac_ctrl;
  logic signed [7:0]  mac_sample;
  logic signed [7:0]  mac_coef;
  logic signed [7:0]  mac_q;

  logic               in_accept;
  logic               out_free;
  logic [7:0]         diff;
  logic               transition;
  logic [PW-1:0]      phase_nudged;
  logic [PW-1:0]      phase_sum;
  logic               phase_wrap;
  logic [1:0]         decided_next;
  logic               new_bit;
  logic               emit;

  afsk_mac u_mac (
    .clk    (clk),
    .ctrl   (mac_ctrl),
    .sample (mac_sample),
    .coef   (mac_coef),
    .fir_q  (mac_q)
  );

  assign s_tready  = (state == ST_IDLE) && !rst;
  assign in_accept = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;

  // Difference of magnitudes and bit timing update.
  always_comb begin
    diff         = mag8(mac_q) - mag8(mark_val);
    transition   = sign_hist[0] ^ sign_hist[1];
    phase_nudged = bit_phase;
    if (transition) begin
      if (bit_phase < PW'(PHASE_MID)) begin
        phase_nudged = bit_phase + PW'(1);
      end else begin
        phase_nudged = bit_phase - PW'(1);
      end
    end
    phase_sum    = phase_nudged + PW'(PHASE_STEP);
    phase_wrap   = (phase_sum >= PW'(PHASE_LIMIT));
    decided_next = {decided[0], is_one_pattern(sign_hist)};
    new_bit      = ~(decided_next[0] ^ decided_next[1]);
    emit         = phase_wrap && (bits_in_byte == 3'd7);
  end

  // Sequencer: next state, tap counter and shared unit operands.
  always_comb begin
    state_next   = state;
    tap_next     = tap;
    tap_last     = 1'b0;
    mac_ctrl.en  = 1'b0;
    mac_ctrl.clr = (tap == '0);
    mac_sample   = 8'sd0;
    mac_coef     = 8'sd0;
    case (state)
      ST_IDLE: begin
        tap_next = '0;
        if (in_accept) begin
          case (mode)
            MODE_PREEMP: state_next = ST_PRE;
            MODE_DEEMP:  state_next = ST_DEEM;
            default:     state_next = ST_MARK;
          endcase
        end
      end
      ST_PRE: begin
        mac_ctrl.en = 1'b1;
        mac_sample  = pre_dly[tap[2:0]];
        mac_coef    = preemph_coef(tap);
        tap_last    = (tap == TAP_W'(PRE_TAPS - 1));
      end
      ST_DEEM: begin
        mac_ctrl.en = 1'b1;
        mac_sample  = deem_dly[tap[2:0]];
        mac_coef    = deemph_coef(tap);
        tap_last    = (tap == TAP_W'(PRE_TAPS - 1));
      end
      ST_MARK: begin
        mac_ctrl.en = 1'b1;
        mac_sample  = mark_dly[tap];
        mac_coef    = mark_coef(tap);
        tap_last    = (tap == TAP_W'(MARK_TAPS - 1));
      end
      ST_SPACE: begin
        mac_ctrl.en = 1'b1;
        mac_sample  = space_dly[tap];
        mac_coef    = space_coef(tap);
        tap_last    = (tap == TAP_W'(SPACE_TAPS - 1));
      end
      ST_LP: begin
        mac_ctrl.en = 1'b1;
        mac_sample  = lp_dly[tap[2:0]];
        mac_coef    = lowpass_coef(tap);
        tap_last    = (tap == TAP_W'(LP_TAPS - 1));
      end
      ST_DECIDE: begin
        state_next = emit ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    // Step through the taps; move to the next filter after the last one.
    if (mac_ctrl.en) begin
      tap_next = tap + TAP_W'(1);
      if (tap_last) begin
        tap_next = '0;
        case (state)
          ST_PRE:   state_next = ST_MARK;
          ST_DEEM:  state_next = ST_MARK;
          ST_MARK:  state_next = ST_SPACE;
          ST_SPACE: state_next = ST_LP;
          default:  state_next = ST_DECIDE;
        endcase
      end
    end
  end

  // State and tap counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      tap   <= '0;
    end else begin
      state <= state_next;
      tap   <= tap_next;
    end
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_NONE;
    end else if (prefilter_mode_we) begin
      mode <= prefilter_mode_wdata;
    end
  end

  // Delay lines, newest entry at index 0.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PRE_TAPS; i++) begin
        pre_dly[i]  <= 8'sd0;
        deem_dly[i] <= 8'sd0;
      end
      for (int i = 0; i < MARK_TAPS; i++) begin
        mark_dly[i]  <= 8'sd0;
        space_dly[i] <= 8'sd0;
      end
      for (int i = 0; i < LP_TAPS; i++) begin
        lp_dly[i] <= 8'sd0;
      end
    end else begin
      // Sample goes to the selected prefilter or straight to the bandpasses.
      if (in_accept) begin
        case (mode)
          MODE_PREEMP: begin
            for (int i = PRE_TAPS - 1; i > 0; i--) pre_dly[i] <= pre_dly[i-1];
            pre_dly[0] <= s_tdata;
          end
          MODE_DEEMP: begin
            for (int i = PRE_TAPS - 1; i > 0; i--) deem_dly[i] <= deem_dly[i-1];
            deem_dly[0] <= s_tdata;
          end
          default: begin
            for (int i = MARK_TAPS - 1; i > 0; i--) mark_dly[i] <= mark_dly[i-1];
            for (int i = SPACE_TAPS - 1; i > 0; i--) space_dly[i] <= space_dly[i-1];
            mark_dly[0]  <= s_tdata;
            space_dly[0] <= s_tdata;
          end
        endcase
      end
      // Prefilter output feeds both bandpasses.
      if ((state == ST_PRE || state == ST_DEEM) && tap_last) begin
        for (int i = MARK_TAPS - 1; i > 0; i--) mark_dly[i] <= mark_dly[i-1];
        for (int i = SPACE_TAPS - 1; i > 0; i--) space_dly[i] <= space_dly[i-1];
        mark_dly[0]  <= mac_q;
        space_dly[0] <= mac_q;
      end
      // Magnitude difference feeds the lowpass.
      if (state == ST_SPACE && tap_last) begin
        for (int i = LP_TAPS - 1; i > 0; i--) lp_dly[i] <= lp_dly[i-1];
        lp_dly[0] <= diff;
      end
    end
  end

  // Mark filter result holds until the space filter is done.
  always_ff @(posedge clk) begin
    if (state == ST_MARK && tap_last) begin
      mark_val <= mac_q;
    end
  end

  // Sign history, bit timing and byte assembly.
  always_ff @(posedge clk) begin
    if (rst) begin
      sign_hist    <= '0;
      bit_phase    <= '0;
      decided      <= '0;
      byte_shift   <= '0;
      bits_in_byte <= '0;
    end else begin
      if (state == ST_LP && tap_last) begin
        sign_hist <= {sign_hist[2:0], (!mac_q[7] && (mac_q != 8'sd0))};
      end
      if (state == ST_DECIDE) begin
        if (phase_wrap) begin
          bit_phase    <= phase_sum - PW'(PHASE_LIMIT);
          decided      <= decided_next;
          byte_shift   <= {new_bit, byte_shift[7:1]};
          bits_in_byte <= bits_in_byte + 3'd1;
        end else begin
          bit_phase <= phase_sum;
        end
      end
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      m_tdata <= byte_shift;
    end
  end

  // Checks on the sequencer and bit timing.
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    bit_phase < PW'(PHASE_LIMIT))
    else $error("bit phase out of range");

  a_accept_starts_work: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> state != ST_IDLE)
    else $error("accepted word did not start the sequencer");

  a_emit_full_byte: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> bits_in_byte == 3'd0)
    else $error("byte emitted before eight bits were collected");

  a_load_after_decide: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ($past(state) == ST_DECIDE || $past(state) == ST_EMIT))
    else $error("emit entered without a decision");

endmodule

@@ test/afsk_bell202_demodulator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bell 202 AFSK demodulator testbench
// Feeds audio samples through the demodulator under every prefilter setting:
// a short table of edge samples first, then synthesized mark/space tone
// bursts mixed with noise, full-scale and constant-level bursts. Every
// decoded byte is checked against a sample-by-sample software demodulator
// kept in step with the accepted input words.
// ----------------------------------------------------------------------------
module afsk_bell202_demodulator_tb;
  import afsk_pkg::*;

  localparam int          CYCLE_LIMIT   = 1000000;
  localparam int          SETTLE_CYCLES = 48;
  localparam int          PHASE_WRAP    = SAMPLES_PER_BIT_DEF * PHASE_STEP_DEF;
  localparam int          PHASE_HALF    = PHASE_WRAP / 2;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;
  localparam logic [15:0] MARK_STEP     = 16'd8192;   // 1200 Hz at 9600 samples/s
  localparam logic [15:0] SPACE_STEP    = 16'd15019;  // 2200 Hz at 9600 samples/s

  typedef enum logic [2:0] {
    F_PRE,
    F_DEEM,
    F_MARK,
    F_SPACE,
    F_LP
  } fir_sel_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] smp;
  } edge_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata = 8'h00;      // [7:0] audio_sample
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;              // [7:0] data_byte
  logic       prefilter_mode_we = 1'b0;
  logic [1:0] prefilter_mode_wdata = 2'd0;

  afsk_bell202_demodulator dut (
    .clk                  (clk),
    .rst                  (rst),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .prefilter_mode_we    (prefilter_mode_we),
    .prefilter_mode_wdata (prefilter_mode_wdata)
  );

  // Filter weights, tap 0 applied to the newest sample.
  int pre_w [5]   = '{-18, -29, 93, -29, -18};
  int deem_w [5]  = '{6, 39, 60, 39, 6};
  int mark_w [11] = '{-12, -16, -15, 0, 20, 29, 20, 0, -15, -16, -12};
  int space_w [11] = '{11, 15, -8, -26, 4, 30, 4, -26, -8, 15, 11};
  int lp_w [8]    = '{-9, 3, 26, 47, 47, 26, 3, -9};

  // One sine period in 32 steps, for the tone synthesizer.
  int sine_tbl [32] = '{0, 25, 49, 71, 90, 106, 117, 125, 127, 125, 117, 106, 90, 71,
                        49, 25, 0, -25, -49, -71, -90, -106, -117, -125, -127, -125,
                        -117, -106, -90, -71, -49, -25};

  // Edge samples under each prefilter; the de-emphasis run of full-scale
  // samples overflows the quotient, and the return to pre-emphasis sees the
  // delay line it left behind.
  edge_row_t edge_rows [24] = '{
    '{MODE_NONE,   8'h00}, '{MODE_NONE,   8'h7f}, '{MODE_NONE,   8'h80},
    '{MODE_NONE,   8'h01}, '{MODE_NONE,   8'hff},
    '{MODE_PREEMP, 8'h7f}, '{MODE_PREEMP, 8'h80}, '{MODE_PREEMP, 8'h7f},
    '{MODE_PREEMP, 8'h80}, '{MODE_PREEMP, 8'h55},
    '{MODE_DEEMP,  8'h7f}, '{MODE_DEEMP,  8'h7f}, '{MODE_DEEMP,  8'h7f},
    '{MODE_DEEMP,  8'h7f}, '{MODE_DEEMP,  8'h7f}, '{MODE_DEEMP,  8'h80},
    '{MODE_DEEMP,  8'h80},
    '{MODE_SPARE,  8'haa}, '{MODE_SPARE,  8'h80}, '{MODE_SPARE,  8'h7f},
    '{MODE_PREEMP, 8'h01}, '{MODE_PREEMP, 8'h00},
    '{MODE_NONE,   8'h80}, '{MODE_NONE,   8'h7f}
  };

  // Demodulator model state.
  logic signed [7:0] fir_taps [5][11];
  logic [1:0]        active_mode;
  logic [7:0]        sign_hist;
  int                bit_phase;
  logic [1:0]        last_decisions;
  logic [7:0]        octet_shift;
  int                bits_gathered;

  logic [7:0] predicted_bytes [$];
  int         snd_idle_pct = 24;
  int         rcv_idle_pct = 66;
  int         samples_sent = 0;
  int         bytes_checked = 0;
  int         err_count = 0;
  int         cycle_count = 0;
  logic [15:0] tone_phase = 16'd0;

  // Clock.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int tap_weight(input fir_sel_t f, input int i);
    case (f)
      F_PRE:   return pre_w[i];
      F_DEEM:  return deem_w[i];
      F_MARK:  return mark_w[i];
      F_SPACE: return space_w[i];
      default: return lp_w[i];
    endcase
  endfunction

  // Shift a sample into one filter, sum in 16 bits with wrap, divide by 128
  // toward zero and keep the low byte.
  function automatic logic signed [7:0] run_filter(input fir_sel_t f,
                                                   input logic signed [7:0] x);
    int          n;
    int          prod;
    int          q;
    logic [15:0] acc;
    case (f)
      F_PRE, F_DEEM: n = 5;
      F_LP:          n = 8;
      default:       n = 11;
    endcase
    for (int i = n - 1; i > 0; i--) fir_taps[f][i] = fir_taps[f][i - 1];
    fir_taps[f][0] = x;
    acc = 16'd0;
    for (int i = 0; i < n; i++) begin
      prod = int'(fir_taps[f][i]) * tap_weight(f, i);
      acc = acc + prod[15:0];
    end
    q = int'($signed(acc)) / 128;
    return q[7:0];
  endfunction

  // Demodulate one audio sample; returns 1 when it completes a byte.
  function automatic logic demod_sample(input logic [7:0] smp, output logic [7:0] octet);
    logic signed [7:0] x;
    logic signed [7:0] mk;
    logic signed [7:0] sp;
    logic signed [7:0] lp;
    logic              one;
    logic              nrz;
    int                mmag;
    int                smag;
    int                diff;
    octet = 8'h00;
    demod_sample = 1'b0;
    x = smp;
    if (active_mode == MODE_PREEMP) x = run_filter(F_PRE, x);
    else if (active_mode == MODE_DEEMP) x = run_filter(F_DEEM, x);
    mk = run_filter(F_MARK, x);
    sp = run_filter(F_SPACE, x);
    mmag = int'(mk);
    smag = int'(sp);
    if (mmag < 0) mmag = -mmag;
    if (smag < 0) smag = -smag;
    diff = smag - mmag;
    lp = run_filter(F_LP, diff[7:0]);
    sign_hist = {sign_hist[6:0], lp > 0};

    // Bit timing: nudge toward the window center on every sign change.
    if (sign_hist[0] ^ sign_hist[1]) begin
      if (bit_phase < PHASE_HALF) bit_phase++;
      else bit_phase--;
    end
    bit_phase += PHASE_STEP_DEF;

    if (bit_phase >= PHASE_WRAP) begin
      bit_phase = bit_phase % PHASE_WRAP;
      case (sign_hist[3:0])
        PAT_A, PAT_B, PAT_C, PAT_D, PAT_E, PAT_F: one = 1'b1;
        default: one = 1'b0;
      endcase
      last_decisions = {last_decisions[0], one};
      // NRZI: no change between decisions is a one.
      nrz = ~(last_decisions[0] ^ last_decisions[1]);
      octet_shift = {nrz, octet_shift[7:1]};
      bits_gathered++;
      if (bits_gathered >= 8) begin
        bits_gathered = 0;
        octet = octet_shift;
        demod_sample = 1'b1;
      end
    end
  endfunction

  // Offer one sample word, wait for it to be taken and predict its effect.
  task automatic push_sample(input logic [7:0] v);
    logic [7:0] octet;
    while ($urandom_range(99) < snd_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    samples_sent++;
    if (demod_sample(v, octet)) predicted_bytes.push_back(octet);
    @(negedge clk);
  endtask

  // Change the prefilter once the block has drained.
  task automatic set_prefilter(input logic [1:0] m);
    s_tvalid <= 1'b0;
    while (predicted_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    prefilter_mode_we    <= 1'b1;
    prefilter_mode_wdata <= m;
    @(negedge clk);
    prefilter_mode_we <= 1'b0;
    active_mode = m;
  endtask

  task automatic report_error(input string msg);
    err_count++;
    if (err_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // One random phase: mostly tone bursts, with noise, full-scale and
  // constant-level bursts mixed in.
  task automatic run_phase(input logic [1:0] m, input int count);
    int sent;
    int kind;
    int len;
    int amp;
    int nz;
    int v;
    int blen;
    int dc;
    logic mark;
    sent = 0;
    set_prefilter(m);
    while (sent < count) begin
      kind = $urandom_range(9);
      if (kind <= 6) begin
        len = $urandom_range(24, 4);
        amp = ($urandom_range(7) == 0) ? 255 : $urandom_range(127, 16);
        nz  = $urandom_range(12);
        for (int b = 0; b < len && sent < count; b++) begin
          mark = $urandom_range(1);
          blen = ($urandom_range(5) == 0) ? $urandom_range(9, 7) : 8;
          for (int j = 0; j < blen && sent < count; j++) begin
            tone_phase = tone_phase + (mark ? MARK_STEP : SPACE_STEP);
            v = sine_tbl[tone_phase[15:11]] * amp / 128
                + int'($urandom_range(2 * nz)) - nz;
            if (v > 127) v = 127;
            if (v < -128) v = -128;
            push_sample(v[7:0]);
            sent++;
          end
        end
      end else begin
        len = $urandom_range(40, 4);
        dc  = $urandom_range(255);
        for (int j = 0; j < len && sent < count; j++) begin
          case (kind)
            7:       v = $urandom_range(255);
            8:       v = $urandom_range(1) ? 8'h7f : 8'h80;
            default: v = dc;
          endcase
          push_sample(v[7:0]);
          sent++;
        end
      end
    end
  endtask

  // Receiver back-pressure.
  always @(negedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= rcv_idle_pct);
  end

  // Compare every byte taken from the block with the oldest prediction.
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_bytes.size() == 0) begin
        report_error($sformatf("unexpected data byte %02h", m_tdata));
      end else begin
        want = predicted_bytes.pop_front();
        bytes_checked++;
        if (m_tdata !== want)
          report_error($sformatf("data byte mismatch: expected %02h, got %02h",
                                 want, m_tdata));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d bytes still expected",
               cycle_count, predicted_bytes.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    // Model starts from the reset state.
    for (int f = 0; f < 5; f++)
      for (int i = 0; i < 11; i++) fir_taps[f][i] = 8'sd0;
    active_mode    = MODE_NONE;
    sign_hist      = 8'h00;
    bit_phase      = 0;
    last_decisions = 2'b00;
    octet_shift    = 8'h00;
    bits_gathered  = 0;

    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Edge samples, switching the prefilter where the table asks.
    for (int r = 0; r < 24; r++) begin
      if (r == 0 || edge_rows[r].mode != active_mode) set_prefilter(edge_rows[r].mode);
      push_sample(edge_rows[r].smp);
    end

    // Random phases: receiver sparse, then sender sparse, then full rate.
    run_phase(MODE_PREEMP, 272);
    run_phase(MODE_DEEMP, 272);
    snd_idle_pct = 66;
    rcv_idle_pct = 24;
    run_phase(MODE_SPARE, 272);
    run_phase(MODE_NONE, 272);
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    run_phase(MODE_DEEMP, 272);
    run_phase(MODE_PREEMP, 272);

    // Drain.
    s_tvalid <= 1'b0;
    while (predicted_bytes.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("%0d audio samples sent under all four prefilter settings, %0d bytes compared,",
             samples_sent, bytes_checked);
    $display("%0d errors in %0d cycles", err_count, cycle_count);
    if (err_count == 0 && predicted_bytes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ afsk_bell202_demodulator.f @@
design/afsk_pkg.sv
design/afsk_mac.sv
design/afsk_bell202_demodulator.sv
test/afsk_bell202_demodulator_tb.sv
